[hdl/windowed_throughput_meter_unit_assert.svh]
// Assertion macros for the windowed throughput meter.
// Used by windowed_throughput_meter_unit.sv; expects clk_i and rst_ni in scope.
`ifndef WINDOWED_THROUGHPUT_METER_UNIT_ASSERT_SVH
`define WINDOWED_THROUGHPUT_METER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define WTM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WTM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/wtm_pkg.sv]
// Package for the windowed throughput meter: widths, ring geometry, types.
// No dependencies; used by windowed_throughput_meter_unit.sv.
`timescale 1ns / 1ps

package wtm_pkg;

  // Ring geometry.
  localparam int RING_DEPTH = 8;
  localparam int SLOT_W     = $clog2(RING_DEPTH);
  localparam int FILL_W     = $clog2(RING_DEPTH + 1);
  localparam int OLD_W      = SLOT_W + 1;

  // Field widths.
  localparam int TIME_W    = 40;
  localparam int BYTE_W    = 48;
  localparam int IVL_W     = 16;
  localparam int SCALE_W   = BYTE_W + 10;
  localparam int HEAD_W    = SCALE_W - BYTE_W;
  localparam int CNT_W     = $clog2(BYTE_W);
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [IVL_W-1:0]  IVL_RESET = IVL_W'(1000);
  localparam logic [BYTE_W-1:0] RATE_MAX  = {BYTE_W{1'b1}};

  // Register index of the sample interval.
  localparam logic REG_INTERVAL = 1'b0;

  // One stored sample.
  typedef struct packed {
    logic [TIME_W-1:0] t;
    logic [BYTE_W-1:0] down;
    logic [BYTE_W-1:0] up;
  } sample_t;

  // Sequencer states.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_SCALE  = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

endpackage

[hdl/windowed_throughput_meter_unit.sv]
// Windowed throughput meter: sample ring, sequencer and shared radix-2 divider.
// Depends on wtm_pkg and windowed_throughput_meter_unit_assert.svh.
`timescale 1ns / 1ps

// Each observation (timestamp, running down/up byte totals, restart flag in tuser)
// may be stored into an eight-entry sample ring, and one result follows per
// observation: the down and up rates in bytes per second between the oldest and
// newest held samples, the window in milliseconds, and flags. The block takes
// one observation at a time. When no window exists the sequencer goes through
// its read, check and done states and then loads the output register; the next
// observation is taken once it is back in idle. Otherwise both rates go through
// one shared restoring divider, one quotient bit per cycle, 48 steps per rate,
// each after a scaling step, and the result is loaded from the done state; a
// rate that saturates skips its division. The output register lets a new
// observation be taken while the previous result still waits.

`include "windowed_throughput_meter_unit_assert.svh"

module windowed_throughput_meter_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Observation stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata, lowest bit up: time_ms[39:0], down_bytes[87:40], up_bytes[135:88]
  input  logic [wtm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: restart
  input  logic                              s_axis_tuser,
  // Result stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata, lowest bit up: down_rate[47:0], up_rate[95:48], window_ms[135:96]
  output logic [wtm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser, lowest bit up: rates_valid, sample_stored
  output logic [1:0]                        m_axis_tuser,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wtm_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [wtm_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [wtm_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import wtm_pkg::*;

  state_e                 state_q, state_d;
  logic [IVL_W-1:0]       ivl_q;
  sample_t                ring_q [RING_DEPTH];
  sample_t                rd_q;
  sample_t                newest_q;
  logic [SLOT_W-1:0]      slot_q;
  logic [FILL_W-1:0]      fill_q;
  logic                   stored_q;
  logic [TIME_W-1:0]      el_q;
  logic [BYTE_W-1:0]      ddiff_q, udiff_q;
  logic                   phase_q;
  logic [TIME_W-1:0]      rem_q;
  logic [BYTE_W-1:0]      acc_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [BYTE_W-1:0]      down_q, up_q;
  logic                   valid_q;
  logic                   ovalid_q;
  logic [OUT_DATA_W-1:0]  odata_q;
  logic [1:0]             ouser_q;

  // Configuration register.
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_INTERVAL) ? APB_DATA_W'(ivl_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ivl_q <= IVL_RESET;
    end else if (cfg_wr && paddr[2] == REG_INTERVAL) begin
      ivl_q <= pwdata[IVL_W-1:0];
    end
  end

  // Input fields.
  sample_t in_s;
  assign in_s.t    = s_axis_tdata[TIME_W-1:0];
  assign in_s.down = s_axis_tdata[TIME_W+BYTE_W-1:TIME_W];
  assign in_s.up   = s_axis_tdata[TIME_W+2*BYTE_W-1:TIME_W+BYTE_W];

  logic in_xfer;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Store decision for the incoming observation.
  logic [FILL_W-1:0] fill_eff;
  logic [TIME_W-1:0] gap;
  logic              seed, append, wr_en;
  logic [SLOT_W-1:0] next_slot, wr_slot;
  assign fill_eff  = s_axis_tuser ? '0 : fill_q;
  assign gap       = in_s.t - newest_q.t;
  assign seed      = (fill_eff == '0);
  assign append    = !seed && (in_s.t >= newest_q.t) && (gap >= TIME_W'(ivl_q));
  assign next_slot = (slot_q == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_q + 1'b1;
  assign wr_slot   = seed ? '0 : next_slot;
  assign wr_en     = in_xfer && (seed || append);

  // Slot of the oldest held sample.
  logic [OLD_W-1:0]  old_sum;
  logic [SLOT_W-1:0] old_slot;
  assign old_sum  = OLD_W'(slot_q) + OLD_W'(RING_DEPTH) - OLD_W'(fill_q) + OLD_W'(1);
  assign old_slot = (old_sum >= OLD_W'(RING_DEPTH)) ?
                    SLOT_W'(old_sum - OLD_W'(RING_DEPTH)) : SLOT_W'(old_sum);

  // Sample ring: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ring_q[wr_slot] <= in_s;
    end
    rd_q <= ring_q[old_slot];
  end

  // Ring pointers and the copy of the newest sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= '0;
      fill_q   <= '0;
      stored_q <= 1'b0;
    end else if (in_xfer) begin
      stored_q <= seed || append;
      if (seed) begin
        slot_q <= '0;
        fill_q <= FILL_W'(1);
      end else if (append) begin
        slot_q <= next_slot;
        if (fill_q != FILL_W'(RING_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end else begin
        fill_q <= fill_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      newest_q <= in_s;
    end
  end

  // Window check on the oldest and newest samples.
  logic have_window;
  assign have_window = (fill_q >= FILL_W'(2)) && (newest_q.t > rd_q.t);

  // Scaling by 1000 and the saturation test.
  logic [BYTE_W-1:0]  scale_in;
  logic [SCALE_W-1:0] scaled;
  logic               sat;
  assign scale_in = phase_q ? udiff_q : ddiff_q;
  assign scaled   = SCALE_W'(scale_in) * SCALE_W'(1000);
  assign sat      = TIME_W'(scaled[SCALE_W-1:BYTE_W]) >= el_q;

  // One restoring divider step.
  logic [TIME_W:0]   trial;
  logic              ge;
  logic [TIME_W-1:0] rem_d;
  logic [BYTE_W-1:0] acc_d;
  assign trial = {rem_q, acc_q[BYTE_W-1]};
  assign ge    = trial >= {1'b0, el_q};
  assign rem_d = ge ? TIME_W'(trial - {1'b0, el_q}) : trial[TIME_W-1:0];
  assign acc_d = {acc_q[BYTE_W-2:0], ge};

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_READ;
      ST_READ:   state_d = ST_CHECK;
      ST_CHECK:  state_d = have_window ? ST_SCALE : ST_DONE;
      ST_SCALE: begin
        if (!sat) state_d = ST_DIVIDE;
        else if (phase_q) state_d = ST_DONE;
      end
      ST_DIVIDE: begin
        if (cnt_q == CNT_W'(BYTE_W - 1)) state_d = phase_q ? ST_DONE : ST_SCALE;
      end
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers of the rate computation.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_CHECK: begin
        el_q    <= newest_q.t - rd_q.t;
        ddiff_q <= newest_q.down - rd_q.down;
        udiff_q <= newest_q.up - rd_q.up;
        valid_q <= have_window;
        phase_q <= 1'b0;
        down_q  <= '0;
        up_q    <= '0;
      end
      ST_SCALE: begin
        rem_q <= TIME_W'(scaled[SCALE_W-1:BYTE_W]);
        acc_q <= scaled[BYTE_W-1:0];
        cnt_q <= '0;
        if (sat) begin
          if (phase_q) up_q <= RATE_MAX;
          else down_q <= RATE_MAX;
          phase_q <= 1'b1;
        end
      end
      ST_DIVIDE: begin
        rem_q <= rem_d;
        acc_q <= acc_d;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(BYTE_W - 1)) begin
          if (phase_q) up_q <= acc_d;
          else down_q <= acc_d;
          phase_q <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register.
  logic load_out;
  assign load_out = (state_q == ST_DONE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      odata_q <= {(valid_q ? el_q : TIME_W'(0)), up_q, down_q};
      ouser_q <= {stored_q, valid_q};
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // Assertions.
  `WTM_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(RING_DEPTH), "fill count above depth")
  `WTM_ASSERT_NOW(a_rem_below_div, state_q == ST_DIVIDE, rem_q < el_q, "remainder not below divisor")
  `WTM_ASSERT_NEXT(a_restart_seeds, in_xfer && s_axis_tuser, stored_q, "restart did not seed ring")
  `WTM_ASSERT_NOW(a_valid_window, m_axis_tvalid && m_axis_tuser[0],
                  m_axis_tdata[OUT_DATA_W-1:2*BYTE_W] != '0, "valid rates with empty window")

endmodule
